### rtl/rsa_kd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key derivation package
// Shared types, constants and state encoding for the key derivation block.
// ----------------------------------------------------------------------------
package rsa_kd_pkg;

    localparam int PRIME_BITS = 16;
    localparam int WORD_BITS  = 32;
    localparam int COEF_BITS  = 64;
    localparam int MAX_STEPS  = 64;
    localparam int STEP_BITS  = $clog2(MAX_STEPS);
    localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

    typedef struct packed {
        logic [15:0] prime_p;
        logic [15:0] prime_q;
        logic [31:0] public_exponent;
    } t_in_item;

    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] private_exponent;
        logic [31:0] common_divisor;
        logic        invertible;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FWD_CHECK,
        ST_DIV,
        ST_DIV_WAIT,
        ST_BACK_RD,
        ST_BACK_MUL,
        ST_BACK_UPD,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic div_start;
        logic div_step;
        logic div_commit;
        logic back_init;
        logic back_rd;
        logic back_mul;
        logic back_upd;
        logic finish;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic a_zero;
        logic depth_full;
        logic div_done;
        logic back_done;
    } t_stat;

endpackage

### rtl/rsa_private_key_derivation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA private key derivation
// Modulus, totient and modular inverse of e by extended Euclid.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start while busy is low; the transaction is
//   taken at that edge. busy stays high until the result is out.
//   The result appears on o_item for one cycle with o_valid high; there is
//   no back-pressure, the receiver must take it then.
// The Euclid loop takes at most 48 steps for 32-bit operands, and far fewer
//   for typical exponents. Each forward step runs the radix-2 divider, one
//   quotient bit per cycle, then commits the quotient and checks for the
//   end; each back-substitution step reads a quotient, multiplies and
//   updates the coefficients.
// One transaction at a time; busy is already low in the o_valid cycle, so
//   the next may be taken at the edge that ends it.
// Reset (synchronous, active low) returns the controller to idle and
// drops o_valid.
// ----------------------------------------------------------------------------
module rsa_private_key_derivation (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rsa_kd_pkg::t_in_item  i_item,
    output logic                  o_valid,
    output rsa_kd_pkg::t_out_item o_item
);

    rsa_kd_pkg::t_ctrl w_ctrl;
    rsa_kd_pkg::t_stat w_stat;

    rsa_kd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    rsa_kd_datapath u_dp (
        .i_clk  (i_clk),
        .i_item (i_item),
        .i_ctrl (w_ctrl),
        .o_stat (w_stat),
        .o_item (o_item)
    );

endmodule

### rtl/rsa_kd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key derivation datapath
// Products, radix-2 divider, quotient store and back-substitution.
// ----------------------------------------------------------------------------
module rsa_kd_datapath (
    input  logic                 i_clk,
    input  rsa_kd_pkg::t_in_item i_item,
    input  rsa_kd_pkg::t_ctrl    i_ctrl,
    output rsa_kd_pkg::t_stat    o_stat,
    output rsa_kd_pkg::t_out_item o_item
);

    localparam int W = rsa_kd_pkg::WORD_BITS;
    localparam int C = rsa_kd_pkg::COEF_BITS;
    localparam int S = rsa_kd_pkg::STEP_BITS;
    localparam int PB = rsa_kd_pkg::PRIME_BITS;

    logic [W-1:0] r_p, r_q, r_a, r_b, r_n, r_phi;
    logic [W-1:0] r_pm1, r_qm1;
    logic [W-1:0] r_quo, r_rem;
    logic [rsa_kd_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [S:0]   r_depth;
    logic [W-1:0] r_qmem [rsa_kd_pkg::MAX_STEPS];
    logic [W-1:0] r_qrd;
    logic [C-1:0] r_x, r_y, r_prod;

    logic [PB-1:0] w_pm, w_qm;
    logic [W:0]   w_trial;
    logic [W-1:0] w_mag, w_d;

    assign w_pm = i_item.prime_p[PB-1:0];
    assign w_qm = i_item.prime_q[PB-1:0];
    assign w_trial = {r_rem, r_b[W-1]} - {1'b0, r_a};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_p   <= W'(w_pm);
            r_q   <= W'(w_qm);
            r_pm1 <= (w_pm != '0) ? W'(w_pm) - W'(1) : '0;
            r_qm1 <= (w_qm != '0) ? W'(w_qm) - W'(1) : '0;
            r_a   <= i_item.public_exponent;
            r_depth <= '0;
        end
        if (i_ctrl.mul_lo) begin
            r_n   <= W'(r_p * r_q);
            r_phi <= W'(r_pm1 * r_qm1);
        end
        if (i_ctrl.div_start) begin
            if (r_depth == '0 && !i_ctrl.mul_lo) r_b <= r_phi;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end
        // b shifts out as dividend bits; quotient collects
        if (i_ctrl.div_step) begin
            if (!w_trial[W]) begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_b[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
            r_b   <= {r_b[W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_ctrl.div_commit) begin
            r_qmem[r_depth[S-1:0]] <= r_quo;
            r_b     <= r_a;
            r_a     <= r_rem;
            r_depth <= r_depth + 1'b1;
        end
        if (i_ctrl.back_init) begin
            r_x <= '0;
            r_y <= C'(1);
        end
        if (i_ctrl.back_rd) begin
            r_qrd   <= r_qmem[S'(r_depth - 1'b1)];
            r_depth <= r_depth - 1'b1;
        end
        if (i_ctrl.back_mul) begin
            r_prod <= C'(r_qrd * r_x[W-1:0]) + {(r_qrd * r_x[C-1:W]), {W{1'b0}}};
        end
        if (i_ctrl.back_upd) begin
            r_x <= r_y - r_prod;
            r_y <= r_x;
        end
        if (i_ctrl.finish) begin
            o_item.modulus          <= r_n;
            o_item.private_exponent <= w_d;
            o_item.common_divisor   <= r_b;
            o_item.invertible       <= (r_b == W'(1));
        end
    end

    // first divide step: b = phi; handled by loading phi into b at div_start
    assign w_mag = W'(C'(0) - r_x);
    assign w_d   = r_x[C-1] ? (r_phi - w_mag) : r_x[W-1:0];

    assign o_stat.a_zero     = (r_a == '0);
    assign o_stat.depth_full = r_depth[S];
    assign o_stat.div_done   = (r_cnt == rsa_kd_pkg::DIV_CNT_BITS'(W));
    assign o_stat.back_done  = (r_depth == '0);

endmodule

### rtl/rsa_kd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key derivation controller
// Sequences multiply, Euclid division steps and back-substitution.
// ----------------------------------------------------------------------------
module rsa_kd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rsa_kd_pkg::t_stat i_stat,
    output rsa_kd_pkg::t_ctrl o_ctrl,
    output logic              o_busy,
    output logic              o_done
);

    rsa_kd_pkg::t_state r_state, n_state;
    logic r_first, n_first;
    logic r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsa_kd_pkg::ST_IDLE;
            r_first <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        n_done  = 1'b0;
        o_ctrl  = '0;
        unique case (r_state)
            rsa_kd_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state = rsa_kd_pkg::ST_MUL;
                end
            end
            rsa_kd_pkg::ST_MUL: begin
                o_ctrl.mul_lo = 1'b1;
                n_first = 1'b1;
                n_state = rsa_kd_pkg::ST_FWD_CHECK;
            end
            rsa_kd_pkg::ST_FWD_CHECK: begin
                if (r_first) begin
                    // load b = phi on the first step even when e is zero
                    o_ctrl.div_start = 1'b1;
                    n_first = 1'b0;
                end
                if (i_stat.a_zero || i_stat.depth_full) begin
                    o_ctrl.back_init = 1'b1;
                    n_state = rsa_kd_pkg::ST_BACK_RD;
                end else begin
                    o_ctrl.div_start = 1'b1;
                    n_state = rsa_kd_pkg::ST_DIV;
                end
            end
            rsa_kd_pkg::ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_done) begin
                    o_ctrl.div_step = 1'b0;
                    n_state = rsa_kd_pkg::ST_DIV_WAIT;
                end
            end
            rsa_kd_pkg::ST_DIV_WAIT: begin
                o_ctrl.div_commit = 1'b1;
                n_state = rsa_kd_pkg::ST_FWD_CHECK;
            end
            rsa_kd_pkg::ST_BACK_RD: begin
                if (i_stat.back_done) begin
                    n_state = rsa_kd_pkg::ST_FINISH;
                end else begin
                    o_ctrl.back_rd = 1'b1;
                    n_state = rsa_kd_pkg::ST_BACK_MUL;
                end
            end
            rsa_kd_pkg::ST_BACK_MUL: begin
                o_ctrl.back_mul = 1'b1;
                n_state = rsa_kd_pkg::ST_BACK_UPD;
            end
            rsa_kd_pkg::ST_BACK_UPD: begin
                o_ctrl.back_upd = 1'b1;
                n_state = rsa_kd_pkg::ST_BACK_RD;
            end
            rsa_kd_pkg::ST_FINISH: begin
                o_ctrl.finish = 1'b1;
                n_done = 1'b1;
                n_state = rsa_kd_pkg::ST_IDLE;
            end
            default: n_state = rsa_kd_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != rsa_kd_pkg::ST_IDLE);
    assign o_done = r_done;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key derivation testbench
// Drives p, q and e into the key derivation block and checks every result
// against an in-bench extended Euclid predictor, with random gaps between
// transactions.
// ----------------------------------------------------------------------------
module testbench;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    rsa_kd_pkg::t_in_item  i_item;
    logic                  o_valid;
    rsa_kd_pkg::t_out_item o_item;

    rsa_kd_pkg::t_out_item key_queue[$];
    int        error_count;
    int        burst_left;

    rsa_private_key_derivation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Extended Euclid with back-substitution in wrapping 64-bit arithmetic.
    function automatic rsa_kd_pkg::t_out_item derive_key(rsa_kd_pkg::t_in_item it);
        logic [63:0] p, q, e, pm1, qm1, phi, a, b, r, x, y, nx, mag;
        logic [63:0] quot[rsa_kd_pkg::MAX_STEPS];
        int          depth;
        rsa_kd_pkg::t_out_item res;
        p = 64'(it.prime_p);
        q = 64'(it.prime_q);
        e = 64'(it.public_exponent);
        pm1 = (p != 0) ? p - 1 : 0;
        qm1 = (q != 0) ? q - 1 : 0;
        phi = (pm1 * qm1) & 64'hFFFF_FFFF;
        a = e;
        b = phi;
        depth = 0;
        while (a != 0 && depth < rsa_kd_pkg::MAX_STEPS) begin
            r = b % a;
            quot[depth] = b / a;
            b = a;
            a = r;
            depth++;
        end
        x = 0;
        y = 1;
        for (int i = depth; i > 0; i--) begin
            nx = y - quot[i-1] * x;
            y = x;
            x = nx;
        end
        if (x[63]) begin
            mag = 64'd0 - x;
            res.private_exponent = 32'(phi - mag);
        end else begin
            res.private_exponent = x[31:0];
        end
        res.modulus = 32'(p * q);
        res.common_divisor = b[31:0];
        res.invertible = (b == 1);
        return res;
    endfunction

    task automatic send_key_request(input logic [15:0] p, input logic [15:0] q,
                                    input logic [31:0] e);
        rsa_kd_pkg::t_in_item it;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        it.prime_p = p;
        it.prime_q = q;
        it.public_exponent = e;
        i_item = it;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        key_queue.push_back(derive_key(it));
        @(negedge i_clk);
        start = 1'b0;
        i_item = '0;
    endtask

    // Checks each result strobe against the oldest pending prediction.
    always @(posedge i_clk) begin
        rsa_kd_pkg::t_out_item exp_key;
        if (i_rst_n && o_valid) begin
            if (key_queue.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                exp_key = key_queue.pop_front();
                if (o_item.modulus !== exp_key.modulus) begin
                    $error("modulus exp %0d got %0d", exp_key.modulus, o_item.modulus);
                    error_count++;
                end
                if (o_item.private_exponent !== exp_key.private_exponent) begin
                    $error("private_exponent exp %0d got %0d",
                           exp_key.private_exponent, o_item.private_exponent);
                    error_count++;
                end
                if (o_item.common_divisor !== exp_key.common_divisor) begin
                    $error("common_divisor exp %0d got %0d",
                           exp_key.common_divisor, o_item.common_divisor);
                    error_count++;
                end
                if (o_item.invertible !== exp_key.invertible) begin
                    $error("invertible exp %0d got %0d",
                           exp_key.invertible, o_item.invertible);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_key_request(16'd61, 16'd53, 32'd17);
        send_key_request(16'd3, 16'd11, 32'd3);
        send_key_request(16'd65521, 16'd65519, 32'd65537);
        send_key_request(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_key_request(16'd0, 16'd13, 32'd7);       // p zero
        send_key_request(16'd17, 16'd0, 32'd7);       // q zero
        send_key_request(16'd1, 16'd1, 32'd5);        // zero totient
        send_key_request(16'd61, 16'd53, 32'd0);      // zero exponent
        send_key_request(16'd0, 16'd0, 32'd0);        // both zero
        send_key_request(16'd61, 16'd53, 32'd6);      // gcd not one
        send_key_request(16'd2, 16'd2, 32'd1);
        send_key_request(16'd7, 16'd11, 32'h8000_0000);
        send_key_request(16'h8000, 16'h0001, 32'd1);
        send_key_request(16'd46368, 16'd2, 32'd28657); // long Euclid chain
        send_key_request(16'd65535, 16'd2, 32'd1);
    endtask

    task automatic test_random();
        logic [15:0] p, q;
        logic [31:0] e;
        for (int n = 0; n < 400; n++) begin
            p = 16'($urandom);
            q = 16'($urandom);
            case ($urandom_range(0, 3))
                0: e = $urandom;
                1: e = $urandom_range(1, 70000);
                2: e = 32'($urandom_range(0, 5)) * 2 + 3;
                default: e = 32'd65537;
            endcase
            if ($urandom_range(0, 15) == 0) begin
                p = 16'($urandom_range(0, 2));
            end
            send_key_request(p, q, e);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        error_count = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        while (key_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

### sim.f
rtl/rsa_kd_pkg.sv
rtl/rsa_kd_datapath.sv
rtl/rsa_kd_ctrl.sv
rtl/rsa_private_key_derivation.sv
test/testbench.sv
